@@ src/nfa_pkg.sv @@
// shared constants, types and helpers for the nfa word acceptor
// no dependencies; used by nfa_engine, nfa_word_acceptor_top and nfa_checker
package nfa_pkg;

    // automaton size
    localparam int NUM_STATES    = 64;
    localparam int ALPHABET_SIZE = 256;

    // fixed field widths
    localparam int FUNC_W       = 2;
    localparam int FIELD_ST_W   = 6;
    localparam int FIELD_SYM_W  = 8;
    localparam int SET_W        = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 64;

    // transition table addressing: state index above symbol
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int SYM_W       = $clog2(ALPHABET_SIZE);
    localparam int ADDR_W      = STATE_W + SYM_W;
    localparam int TABLE_DEPTH = 2 ** ADDR_W;

    // bits of a set that stand for real states
    localparam logic [SET_W-1:0] STATE_MASK = (NUM_STATES >= SET_W) ? {SET_W{1'b1}} :
        ((SET_W'(1) << NUM_STATES) - SET_W'(1));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'b1;

    // word function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_EDGE = 2'd0,
        FUNC_START    = 2'd1,
        FUNC_SYMBOL   = 2'd2,
        FUNC_END      = 2'd3
    } func_t;

    // configuration seen by the engine
    typedef struct packed {
        logic [FIELD_ST_W-1:0] start_state;
        logic [SET_W-1:0]      final_mask;
    } cfg_t;

    // state index below the automaton size
    function automatic logic state_ok(input logic [FIELD_ST_W-1:0] s);
        return ({1'b0, s} < (FIELD_ST_W + 1)'(NUM_STATES));
    endfunction

    // symbol below the alphabet size
    function automatic logic sym_ok(input logic [FIELD_SYM_W-1:0] c);
        return ({1'b0, c} < (FIELD_SYM_W + 1)'(ALPHABET_SIZE));
    endfunction

    // table entry of one state and symbol
    function automatic logic [ADDR_W-1:0] table_addr(input logic [STATE_W-1:0] s,
                                                     input logic [SYM_W-1:0] c);
        return {s, c};
    endfunction

endpackage

@@ src/nfa_ram.sv @@
// generic single-clock ram, one write and one read port, registered read
// no dependencies
module nfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/nfa_engine.sv @@
// sequencer for the nfa acceptor: table clearing, edge read-modify-write,
// symbol walk over all states, result register; uses nfa_pkg
module nfa_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nfa_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [nfa_pkg::FUNC_W-1:0]          func,
    input  logic [nfa_pkg::FIELD_ST_W-1:0]      from_state,
    input  logic [nfa_pkg::FIELD_ST_W-1:0]      to_state,
    input  logic [nfa_pkg::FIELD_SYM_W-1:0]     symbol,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [nfa_pkg::SET_W-1:0]           active_set,
    output logic                                ram_we,
    output logic [nfa_pkg::ADDR_W-1:0]          ram_waddr,
    output logic [nfa_pkg::SET_W-1:0]           ram_wdata,
    output logic                                ram_re,
    output logic [nfa_pkg::ADDR_W-1:0]          ram_raddr,
    input  logic [nfa_pkg::SET_W-1:0]           ram_rdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_WR,
        ST_SYM_RUN,
        ST_SYM_DRAIN,
        ST_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [nfa_pkg::SET_W-1:0]          active_reg, active_next;
    logic [nfa_pkg::SET_W-1:0]          acc_reg, acc_next;
    logic                               hit_reg, hit_next;
    logic [nfa_pkg::STATE_W-1:0]        from_reg, from_next;
    logic [nfa_pkg::FIELD_ST_W-1:0]     to_reg, to_next;
    logic [nfa_pkg::FIELD_SYM_W-1:0]    sym_reg, sym_next;
    logic [nfa_pkg::STATE_W-1:0]        idx_reg, idx_next;
    logic [nfa_pkg::ADDR_W-1:0]         clr_reg, clr_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               accepted_reg, accepted_next;
    logic [nfa_pkg::SET_W-1:0]          active_set_reg, active_set_next;
    logic [nfa_pkg::SET_W-1:0]          acc_in;
    nfa_pkg::func_t                     func_in;

    assign func_in  = nfa_pkg::func_t'(func);
    assign in_stall = (state_reg != ST_IDLE);

    // table row returned this cycle joins the union when its state was active
    assign acc_in = acc_reg | (hit_reg ? ram_rdata : '0);

    // next state and memory control
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        acc_next        = acc_reg;
        hit_next        = 1'b0;
        from_next       = from_reg;
        to_next         = to_reg;
        sym_next        = sym_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        accepted_next   = accepted_reg;
        active_set_next = active_set_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // one table entry zeroed per cycle after reset
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == {nfa_pkg::ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + nfa_pkg::ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func_in)
                        nfa_pkg::FUNC_ADD_EDGE:
                        begin
                            // fetch the row now, merge the new bit next cycle
                            from_next = from_state[nfa_pkg::STATE_W-1:0];
                            to_next   = to_state;
                            sym_next  = symbol;
                            if (nfa_pkg::state_ok(from_state) && nfa_pkg::state_ok(to_state)
                                && nfa_pkg::sym_ok(symbol))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = nfa_pkg::table_addr(
                                    from_state[nfa_pkg::STATE_W-1:0],
                                    symbol[nfa_pkg::SYM_W-1:0]);
                                state_next = ST_EDGE_WR;
                            end
                        end
                        nfa_pkg::FUNC_START:
                        begin
                            if (nfa_pkg::state_ok(cfg.start_state))
                            begin
                                active_next = nfa_pkg::SET_W'(1) << cfg.start_state;
                            end
                            else
                            begin
                                active_next = '0;
                            end
                        end
                        nfa_pkg::FUNC_SYMBOL:
                        begin
                            sym_next   = symbol;
                            idx_next   = '0;
                            acc_next   = '0;
                            state_next = ST_SYM_RUN;
                        end
                        nfa_pkg::FUNC_END:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EDGE_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nfa_pkg::table_addr(from_reg, sym_reg[nfa_pkg::SYM_W-1:0]);
                ram_wdata  = ram_rdata | (nfa_pkg::SET_W'(1) << to_reg);
                state_next = ST_IDLE;
            end
            ST_SYM_RUN:
            begin
                // one row read per state, rows of inactive states are dropped
                ram_re    = 1'b1;
                ram_raddr = nfa_pkg::table_addr(idx_reg, sym_reg[nfa_pkg::SYM_W-1:0]);
                acc_next  = acc_in;
                hit_next  = active_reg[idx_reg] & nfa_pkg::sym_ok(sym_reg);
                if (idx_reg == nfa_pkg::STATE_W'(nfa_pkg::NUM_STATES - 1))
                begin
                    state_next = ST_SYM_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + nfa_pkg::STATE_W'(1);
                end
            end
            ST_SYM_DRAIN:
            begin
                active_next = acc_in & nfa_pkg::STATE_MASK;
                acc_next    = '0;
                state_next  = ST_IDLE;
            end
            ST_EMIT:
            begin
                // wait for a free result register
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    active_set_next = active_reg & nfa_pkg::STATE_MASK;
                    accepted_next   = |(active_reg & cfg.final_mask & nfa_pkg::STATE_MASK);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            active_reg     <= '0;
            acc_reg        <= '0;
            hit_reg        <= 1'b0;
            from_reg       <= '0;
            to_reg         <= '0;
            sym_reg        <= '0;
            idx_reg        <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            accepted_reg   <= 1'b0;
            active_set_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            acc_reg        <= acc_next;
            hit_reg        <= hit_next;
            from_reg       <= from_next;
            to_reg         <= to_next;
            sym_reg        <= sym_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            accepted_reg   <= accepted_next;
            active_set_reg <= active_set_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign active_set = active_set_reg;

endmodule

@@ src/nfa_word_acceptor_top.sv @@
// Nondeterministic finite automaton word acceptor. Edges go into a transition
// table held in one synchronous ram of 16384 rows of 64 bits (one row per
// state and symbol). After reset the block zeroes that table, one row a cycle;
// in_stall stays high during the pass, configuration writes are taken
// throughout. Then one word is worked at a time: add edge reads the row, then
// writes it back with the new bit (an edge out of range is dropped at once),
// start word is done in the idle state, end word waits for any drain of the
// result register, and a symbol walks the table, reading the row of every state
// in turn through the single read port of the table ram. Results appear only
// for end word, one per such word.
// depends on nfa_pkg, nfa_ram, nfa_engine
module nfa_word_acceptor_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [nfa_pkg::FUNC_W-1:0]          func,
    input  logic [nfa_pkg::FIELD_ST_W-1:0]      from_state,
    input  logic [nfa_pkg::FIELD_ST_W-1:0]      to_state,
    input  logic [nfa_pkg::FIELD_SYM_W-1:0]     symbol,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [nfa_pkg::SET_W-1:0]           active_set
);

    logic [nfa_pkg::FIELD_ST_W-1:0] start_state_reg, start_state_next;
    logic [nfa_pkg::SET_W-1:0]      final_mask_reg, final_mask_next;
    nfa_pkg::cfg_t                  cfg;

    logic                           ram_we;
    logic [nfa_pkg::ADDR_W-1:0]     ram_waddr;
    logic [nfa_pkg::SET_W-1:0]      ram_wdata;
    logic                           ram_re;
    logic [nfa_pkg::ADDR_W-1:0]     ram_raddr;
    logic [nfa_pkg::SET_W-1:0]      ram_rdata;

    // configuration register writes
    always_comb
    begin
        start_state_next = start_state_reg;
        final_mask_next  = final_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                nfa_pkg::CFG_START_STATE:
                begin
                    start_state_next = cfg_data[nfa_pkg::FIELD_ST_W-1:0];
                end
                nfa_pkg::CFG_FINAL_MASK:
                begin
                    final_mask_next = cfg_data[nfa_pkg::SET_W-1:0];
                end
                default:
                begin
                    start_state_next = start_state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
        end
        else
        begin
            start_state_reg <= start_state_next;
            final_mask_reg  <= final_mask_next;
        end
    end

    assign cfg.start_state = start_state_reg;
    assign cfg.final_mask  = final_mask_reg;

    // transition table
    nfa_ram #(
        .WIDTH (nfa_pkg::SET_W),
        .DEPTH (nfa_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    nfa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .from_state (from_state),
        .to_state   (to_state),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .active_set (active_set),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule

@@ src/nfa_checker.sv @@
// port-level checks on the nfa word acceptor, bound to the top level
// depends on nfa_pkg for widths
module nfa_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [nfa_pkg::FUNC_W-1:0]          func,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                accepted,
    input  logic [nfa_pkg::SET_W-1:0]           active_set
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(active_set))
        else $error("result changed while stalled");

    // an accepted word needs some active state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> (active_set != '0))
        else $error("accepted with empty active set");

    // symbol and end word keep the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
        && (func == nfa_pkg::FUNC_SYMBOL || func == nfa_pkg::FUNC_END) |=> in_stall)
        else $error("second word taken while busy");

endmodule

bind nfa_word_acceptor_top nfa_checker u_nfa_checker (.*);
